// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

  // Command codes carried in the input kind field
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ      = 3'd4,
    CMD_SEND_ACK  = 3'd5,
    CMD_CHECK_ACK = 3'd6,
    CMD_RSVD      = 3'd7
  } cmd_t;

  localparam int unsigned DELAY_W     = 10;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd6;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  // Register index on the configuration port
  localparam logic REG_DELAY = 1'b0;

  // Result of one tick
  typedef struct packed {
    logic       rejected;
    logic       ack_seen;
    logic [7:0] read_value;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl_level;
  } res_t;

endpackage

// ===== rtl/i2cm_seq.sv =====
`timescale 1ns / 1ps

module i2cm_seq import i2cm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick_en,
  input  logic [2:0]         kind,
  input  logic [7:0]         data_byte,
  input  logic               sda_in,
  input  logic [DELAY_W-1:0] delay_ticks,
  output res_t               res
);

  logic [2:0]         phase_r, phase_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [DELAY_W-1:0] wait_r, wait_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_low_r, sda_low_nxt;
  logic [7:0]         last_read_r, last_read_nxt;
  logic               ack_r, ack_nxt;

  logic               is_cmd;
  logic               seg;
  logic               done;
  logic               rej;
  logic [DELAY_W-1:0] slot;

  assign is_cmd = (kind != CMD_NONE) && (kind != CMD_RSVD);
  // a zero delay behaves as one tick
  assign slot   = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;

  // Next state for one tick: count down the slot, then run the next line change
  always_comb begin
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    wait_nxt      = wait_r;
    scl_nxt       = scl_r;
    sda_low_nxt   = sda_low_r;
    last_read_nxt = last_read_r;
    ack_nxt       = ack_r;
    seg           = 1'b0;
    done          = 1'b0;
    rej           = 1'b0;

    if (cmd_r != CMD_NONE) begin
      rej = is_cmd;
      if (wait_r <= DELAY_W'(1)) begin
        wait_nxt = '0;
        seg      = 1'b1;
      end else begin
        wait_nxt = wait_r - DELAY_W'(1);
      end
    end else if (is_cmd) begin
      cmd_nxt   = cmd_t'(kind);
      phase_nxt = 3'd0;
      bit_nxt   = 4'd0;
      shift_nxt = (kind == CMD_WRITE) ? data_byte : 8'h00;
      seg       = 1'b1;
    end

    if (seg) begin
      unique case (cmd_nxt)
        CMD_START, CMD_STOP: begin
          unique case (phase_nxt)
            3'd0: begin
              sda_low_nxt = (cmd_nxt == CMD_STOP);
              phase_nxt = 3'd1; wait_nxt = slot;
            end
            3'd1: begin scl_nxt = 1'b1; phase_nxt = 3'd2; wait_nxt = slot; end
            3'd2: begin
              sda_low_nxt = (cmd_nxt == CMD_START);
              phase_nxt = 3'd3; wait_nxt = slot;
            end
            3'd3: begin phase_nxt = 3'd4; wait_nxt = slot; end
            default: begin
              cmd_nxt = CMD_NONE; phase_nxt = 3'd0; wait_nxt = '0; done = 1'b1;
            end
          endcase
        end
        CMD_WRITE: begin
          unique case (phase_nxt)
            3'd0: begin scl_nxt = 1'b0; phase_nxt = 3'd1; wait_nxt = slot; end
            3'd1: begin
              sda_low_nxt = ~shift_nxt[7];
              phase_nxt = 3'd2; wait_nxt = slot;
            end
            3'd2: begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_nxt[6:0], 1'b0};
              bit_nxt   = bit_nxt + 4'd1;
              phase_nxt = 3'd3; wait_nxt = slot;
            end
            3'd3: begin
              if (bit_nxt >= BITS_PER_BYTE) begin
                cmd_nxt = CMD_NONE; phase_nxt = 3'd0; wait_nxt = '0; done = 1'b1;
              end else begin
                scl_nxt = 1'b0; phase_nxt = 3'd1; wait_nxt = slot;
              end
            end
            default: begin
              cmd_nxt = CMD_NONE; phase_nxt = 3'd0; wait_nxt = '0; done = 1'b1;
            end
          endcase
        end
        CMD_READ: begin
          unique case (phase_nxt)
            3'd0: begin sda_low_nxt = 1'b0; phase_nxt = 3'd1; wait_nxt = slot; end
            3'd1: begin scl_nxt = 1'b0; phase_nxt = 3'd2; wait_nxt = slot; end
            3'd2: begin phase_nxt = 3'd3; wait_nxt = slot; end
            3'd3: begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_nxt[6:0], sda_in};
              bit_nxt   = bit_nxt + 4'd1;
              phase_nxt = 3'd4; wait_nxt = slot;
            end
            3'd4: begin
              scl_nxt = 1'b0;
              if (bit_nxt >= BITS_PER_BYTE) begin
                last_read_nxt = shift_nxt;
                cmd_nxt = CMD_NONE; phase_nxt = 3'd0; wait_nxt = '0; done = 1'b1;
              end else begin
                phase_nxt = 3'd2; wait_nxt = slot;
              end
            end
            default: begin
              cmd_nxt = CMD_NONE; phase_nxt = 3'd0; wait_nxt = '0; done = 1'b1;
            end
          endcase
        end
        CMD_SEND_ACK: begin
          unique case (phase_nxt)
            3'd0: begin scl_nxt = 1'b0; phase_nxt = 3'd1; wait_nxt = slot; end
            3'd1: begin sda_low_nxt = 1'b1; phase_nxt = 3'd2; wait_nxt = slot; end
            3'd2: begin scl_nxt = 1'b1; phase_nxt = 3'd3; wait_nxt = slot; end
            default: begin
              scl_nxt = 1'b0;
              cmd_nxt = CMD_NONE; phase_nxt = 3'd0; wait_nxt = '0; done = 1'b1;
            end
          endcase
        end
        CMD_CHECK_ACK: begin
          unique case (phase_nxt)
            3'd0: begin
              scl_nxt = 1'b0; sda_low_nxt = 1'b0;
              phase_nxt = 3'd1; wait_nxt = slot;
            end
            3'd1: begin phase_nxt = 3'd2; wait_nxt = slot; end
            3'd2: begin scl_nxt = 1'b1; phase_nxt = 3'd3; wait_nxt = slot; end
            default: begin
              // sample after the rising edge of SCL
              ack_nxt = ~sda_in;
              scl_nxt = 1'b0;
              cmd_nxt = CMD_NONE; phase_nxt = 3'd0; wait_nxt = '0; done = 1'b1;
            end
          endcase
        end
        default: begin
          cmd_nxt = CMD_NONE; phase_nxt = 3'd0; wait_nxt = '0; done = 1'b1;
        end
      endcase
    end
  end

  // Hold the sequencer state, advance on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 3'd0;
      cmd_r       <= CMD_NONE;
      bit_r       <= 4'd0;
      shift_r     <= 8'h00;
      wait_r      <= '0;
      scl_r       <= 1'b1;
      sda_low_r   <= 1'b0;
      last_read_r <= 8'h00;
      ack_r       <= 1'b0;
    end else if (tick_en) begin
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      wait_r      <= wait_nxt;
      scl_r       <= scl_nxt;
      sda_low_r   <= sda_low_nxt;
      last_read_r <= last_read_nxt;
      ack_r       <= ack_nxt;
    end
  end

  // Result of this tick, taken by the output register
  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_pull_low = sda_low_nxt;
    res.busy_res     = (cmd_nxt != CMD_NONE);
    res.done_res     = done;
    res.read_value   = last_read_nxt;
    res.ack_seen     = ack_nxt;
    res.rejected     = rej;
  end

endmodule

// ===== rtl/i2cm_out_reg.sv =====
`timescale 1ns / 1ps

module i2cm_out_reg import i2cm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  input  logic out_tready,
  output logic out_tvalid,
  output res_t res_out,
  output logic space
);

  logic valid_r, valid_nxt;
  res_t data_r;

  // Room for a new result when empty or draining this cycle
  assign space     = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload with each accepted request
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_tvalid = valid_r;
  assign res_out    = data_r;

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps

// I2C master bit engine. Each request on the in_ channel is one bus tick:
// in_tuser carries the command (none, start, stop, write, read, send ack,
// check ack), in_tdata the byte to write and the sampled SDA level. For
// every request exactly one result leaves on the out_ channel with the
// driven SCL level, the SDA pull-down, busy, a done pulse, the last read
// byte, the last ACK check and a flag for a command refused while busy.
// The result is registered and leaves in the cycle after its request; one
// request is taken every clock while the receiver keeps up, set by the single
// output register, which lets a new request in while the previous result is
// being taken. When the receiver stalls, the result holds and in_tready drops until it is taken.
// The APB port sets delay_ticks (byte address 0), ticks per delay slot.
// Reset leaves SCL high, SDA released, the engine idle, the output empty
// and delay_ticks at 6.
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] sda_in, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] read_value, [12] ack_seen, [13] rejected, rest zero
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic               in_fire;
  logic               space;
  logic               cfg_wr;
  logic [DELAY_W-1:0] delay_r;
  res_t               res;
  res_t               res_q;

  assign in_tready  = space;
  assign in_fire    = in_tvalid && space;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_DELAY)) begin
      delay_r <= cfg_pwdata[DELAY_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_DELAY) ? {{(32-DELAY_W){1'b0}}, delay_r} : 32'h0;

  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (in_fire),
    .kind        (in_tuser),
    .data_byte   (in_tdata[7:0]),
    .sda_in      (in_tdata[8]),
    .delay_ticks (delay_r),
    .res         (res)
  );

  i2cm_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .res_in     (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_out    (res_q),
    .space      (space)
  );

  assign out_tdata = {2'b00, res_q};

  // A finished command is no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_q.done_res |-> !res_q.busy_res)
    else $error("done result still flagged busy");

  // A refused command only while a command runs or just ended
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_q.rejected |-> res_q.busy_res || res_q.done_res)
    else $error("command refused while idle");

  // Every accepted tick yields a result in the next cycle
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted tick produced no result");

endmodule
